// File: design/cscv_pkg.sv
// ----------------------------------------------------------------------------
// cscv_pkg
// Shared types and constants of the camera source and volume controller.
// ----------------------------------------------------------------------------
package cscv_pkg;

	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned TIMER_W = 10;
	localparam int unsigned VOL_W   = 10;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic {
		MODE_TICK   = 1'b0,
		MODE_SAMPLE = 1'b1
	} item_mode_t;

	typedef enum logic [1:0] {
		BTN_NONE,
		BTN_CAMERA,
		BTN_AUDIO,
		BTN_ERROR
	} btn_t;

	typedef enum logic [1:0] {
		PULSE_NONE = 2'd0,
		PULSE_UP   = 2'd1,
		PULSE_DOWN = 2'd2
	} pulse_t;

	typedef enum logic [1:0] {
		SRC_OFF   = 2'd0,
		SRC_FRONT = 2'd1,
		SRC_REAR  = 2'd2,
		SRC_THIRD = 2'd3
	} source_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NO_BUTTON_LEVEL  = 3'd0,
		REG_CAMERA_LEVEL     = 3'd1,
		REG_AUDIO_LEVEL      = 3'd2,
		REG_MATCH_WINDOW     = 3'd3,
		REG_THIRD_ENABLE     = 3'd4,
		REG_VOLUME_DEFAULT   = 3'd5
	} cfg_idx_t;

	localparam logic [LEVEL_W-1:0] MATCH_WINDOW_RST = 10'd20;

	typedef struct packed {
		logic [LEVEL_W-1:0] no_button_level;
		logic [LEVEL_W-1:0] camera_button_level;
		logic [LEVEL_W-1:0] audio_button_level;
		logic [LEVEL_W-1:0] match_window;
		logic               third_channel_enable;
		logic               volume_default;
	} cfg_t;

	typedef struct packed {
		item_mode_t         mode;
		logic [1:0]         encoder_phases;
		logic [LEVEL_W-1:0] first_reading;
		logic [LEVEL_W-1:0] second_reading;
		logic [1:0]         readings_valid;
		logic               rear_gear;
	} item_t;

	typedef struct packed {
		source_t    camera_source;
		logic       video_enable;
		logic       front_select;
		logic       third_select;
		logic       volume_active;
		logic [1:0] menu_phases;
		pulse_t     volume_pulse;
		logic       volume_bar_blip;
	} res_t;

	// Quadrature step for {previous phases, current phases}, two's complement.
	function automatic logic [1:0] enc_step(input logic [3:0] idx);
		logic [1:0] s;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: s = 2'b01;
			4'd2, 4'd4, 4'd11, 4'd13: s = 2'b11;
			default: s = 2'b00;
		endcase
		return s;
	endfunction

endpackage

// File: design/cscv_classify.sv
// ----------------------------------------------------------------------------
// cscv_classify
// Matches one button ADC reading against the calibrated levels.
// ----------------------------------------------------------------------------
module cscv_classify (
	input  logic [cscv_pkg::LEVEL_W-1:0] reading,
	input  logic                         valid,
	input  cscv_pkg::cfg_t               cfg,
	output cscv_pkg::btn_t               btn
);
	import cscv_pkg::*;

	// level - w <= r <= level + w, done without going negative
	function automatic logic in_win(input logic [LEVEL_W-1:0] r,
	                                input logic [LEVEL_W-1:0] lvl,
	                                input logic [LEVEL_W-1:0] w);
		logic [LEVEL_W:0] rw;
		logic [LEVEL_W:0] lw;
		rw = {1'b0, r} + {1'b0, w};
		lw = {1'b0, lvl} + {1'b0, w};
		return (rw >= {1'b0, lvl}) && ({1'b0, r} <= lw);
	endfunction

	logic hit_cam, hit_aud, hit_none;

	assign hit_cam  = in_win(reading, cfg.camera_button_level, cfg.match_window);
	assign hit_aud  = in_win(reading, cfg.audio_button_level, cfg.match_window);
	assign hit_none = in_win(reading, cfg.no_button_level, cfg.match_window);

	// camera has priority, then audio, then the idle level
	always_comb begin
		if (!valid)        btn = BTN_ERROR;
		else if (hit_cam)  btn = BTN_CAMERA;
		else if (hit_aud)  btn = BTN_AUDIO;
		else if (hit_none) btn = BTN_NONE;
		else               btn = BTN_ERROR;
	end

endmodule

// File: design/cscv_core.sv
// ----------------------------------------------------------------------------
// cscv_core
// Controller state and its combinational update for one tick or sample.
// ----------------------------------------------------------------------------
module cscv_core #(
	parameter int unsigned FRONT_HOLD_TICKS = 1000,
	parameter int unsigned MODE_HOLD_TICKS  = 600
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  cscv_pkg::item_t item,
	input  cscv_pkg::cfg_t  cfg,
	input  logic            vdef_load,
	input  logic            vdef_value,
	output cscv_pkg::res_t  res
);
	import cscv_pkg::*;

	localparam logic [TIMER_W-1:0] FRONT_HOLD = TIMER_W'(FRONT_HOLD_TICKS);
	localparam logic [TIMER_W-1:0] MODE_HOLD  = TIMER_W'(MODE_HOLD_TICKS);
	localparam logic [VOL_W-1:0]   VOL_MAX    = {1'b0, {(VOL_W-1){1'b1}}};
	localparam logic [VOL_W-1:0]   VOL_MIN    = {1'b1, {(VOL_W-1){1'b0}}};
	localparam logic [VOL_W-1:0]   VOL_ONE    = VOL_W'(1);
	localparam logic [VOL_W-1:0]   VOL_TWO    = VOL_W'(2);

	source_t            src_q, src_d;
	logic               rear_last_q, rear_last_d;
	logic               rear_seen_q, rear_seen_d;
	logic [TIMER_W-1:0] ft_q, ft_d;
	logic [TIMER_W-1:0] mt_q, mt_d;
	logic               vmf_q, vmf_d;
	logic [VOL_W-1:0]   vt_q, vt_d;
	logic [1:0]         enc_last_q, enc_last_d;
	logic [1:0]         menu_q, menu_d;

	btn_t       btn1, btn2, pressed;
	logic [1:0] stp;
	logic [VOL_W:0] vt_sum;
	pulse_t     pulse;
	logic       blip;

	cscv_classify u_cls1 (
		.reading (item.first_reading),
		.valid   (item.readings_valid[0]),
		.cfg     (cfg),
		.btn     (btn1)
	);

	cscv_classify u_cls2 (
		.reading (item.second_reading),
		.valid   (item.readings_valid[1]),
		.cfg     (cfg),
		.btn     (btn2)
	);

	assign pressed = (btn1 == btn2) ? btn1 : BTN_NONE;
	assign stp     = enc_step({enc_last_q, item.encoder_phases});
	assign vt_sum  = {vt_q[VOL_W-1], vt_q} + {{(VOL_W-1){stp[1]}}, stp};

	always_comb begin
		src_d       = src_q;
		rear_last_d = rear_last_q;
		rear_seen_d = rear_seen_q;
		ft_d        = ft_q;
		mt_d        = mt_q;
		vmf_d       = vmf_q;
		vt_d        = vt_q;
		enc_last_d  = enc_last_q;
		menu_d      = menu_q;
		pulse       = PULSE_NONE;
		blip        = 1'b0;

		if (item.mode == MODE_TICK) begin
			if (ft_q != '0) begin
				ft_d = ft_q - TIMER_W'(1);
				if (ft_d == '0) src_d = SRC_OFF;
			end
			if (mt_q != '0) begin
				mt_d = mt_q - TIMER_W'(1);
				if (mt_d == '0) vmf_d = cfg.volume_default;
			end
			if (item.encoder_phases != enc_last_q) begin
				if (vmf_d) begin
					// saturate on signed overflow
					if (vt_sum[VOL_W] != vt_sum[VOL_W-1])
						vt_d = vt_sum[VOL_W] ? VOL_MIN : VOL_MAX;
					else
						vt_d = vt_sum[VOL_W-1:0];
				end else begin
					menu_d = ~item.encoder_phases;
					if (cfg.volume_default) mt_d = MODE_HOLD;
				end
				enc_last_d = item.encoder_phases;
			end
		end else begin
			if (pressed == BTN_ERROR) begin
				vmf_d = cfg.volume_default;
				mt_d  = '0;
				vt_d  = '0;
			end
			if (pressed == BTN_CAMERA) begin
				ft_d  = '0;
				src_d = source_t'(src_q + 2'd1);
				if (!cfg.third_channel_enable && src_d == SRC_THIRD) src_d = SRC_OFF;
			end
			if (pressed == BTN_AUDIO) begin
				vt_d = '0;
				if (vmf_q) begin
					vmf_d = 1'b0;
					if (!cfg.volume_default) begin
						mt_d = '0;
						ft_d = '0;
					end
				end else begin
					vmf_d = 1'b1;
					if (cfg.volume_default) begin
						mt_d = '0;
						ft_d = '0;
					end else begin
						mt_d = MODE_HOLD;
					end
					blip = 1'b1;
				end
			end
			if (!rear_seen_q) begin
				rear_seen_d = 1'b1;
				rear_last_d = item.rear_gear;
			end else if (item.rear_gear != rear_last_q) begin
				rear_last_d = item.rear_gear;
				if (item.rear_gear) begin
					ft_d  = '0;
					src_d = SRC_REAR;
				end else begin
					src_d = SRC_FRONT;
					ft_d  = FRONT_HOLD;
				end
			end
			// at most one volume pulse per sample, taking up to two steps of target each
			if (vt_d != '0) begin
				if (!cfg.volume_default) mt_d = MODE_HOLD;
				if (!vt_d[VOL_W-1]) begin
					pulse = PULSE_UP;
					vt_d  = (vt_d == VOL_ONE) ? '0 : vt_d - VOL_TWO;
				end else begin
					pulse = PULSE_DOWN;
					vt_d  = (vt_d == '1) ? '0 : vt_d + VOL_TWO;
				end
			end
		end
	end

	always_comb begin
		res.camera_source   = src_d;
		res.video_enable    = (src_d != SRC_OFF);
		res.front_select    = (src_d == SRC_FRONT);
		res.third_select    = (src_d == SRC_THIRD);
		res.volume_active   = vmf_d;
		res.menu_phases     = menu_d;
		res.volume_pulse    = pulse;
		res.volume_bar_blip = blip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q       <= SRC_OFF;
			rear_last_q <= 1'b0;
			rear_seen_q <= 1'b0;
			ft_q        <= '0;
			mt_q        <= '0;
			vmf_q       <= 1'b0;
			vt_q        <= '0;
			enc_last_q  <= '0;
			menu_q      <= '0;
		end else if (vdef_load) begin
			vmf_q <= vdef_value;
		end else if (step) begin
			src_q       <= src_d;
			rear_last_q <= rear_last_d;
			rear_seen_q <= rear_seen_d;
			ft_q        <= ft_d;
			mt_q        <= mt_d;
			vmf_q       <= vmf_d;
			vt_q        <= vt_d;
			enc_last_q  <= enc_last_d;
			menu_q      <= menu_d;
		end
	end

	// ticks never pulse the volume lines
	a_tick_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == MODE_TICK |-> res.volume_pulse == PULSE_NONE && !res.volume_bar_blip)
		else $error("volume pulse on a tick");

	// the blip only comes with entering volume mode
	a_blip_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res.volume_bar_blip |-> res.volume_active)
		else $error("volume bar blip outside volume mode");

	// first rear level is captured once and kept
	a_rear_seen: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(rear_seen_q))
		else $error("rear capture flag dropped");

endmodule

// File: design/camera_source_and_volume_controller_unit.sv
// ----------------------------------------------------------------------------
// camera_source_and_volume_controller_unit
// Camera source selection, encoder mode and volume pulse controller.
// ----------------------------------------------------------------------------
// Each input transfer is either a 10 ms tick (mode 0: counts down the front
// and mode hold timers, decodes the encoder phases into volume steps or passes
// them out inverted in menu mode) or a main-loop sample (mode 1: classifies
// both button readings, cycles the camera source, toggles volume mode, follows
// rear-gear edges and issues at most one volume pulse). Every input transfer
// produces exactly one output transfer. Throughput is one item per clock
// while out_ready is high; each item is held in the input register and
// reaches the result register through the combinational update in
// cscv_core. The input register also acts as a skid stage, so one item is
// taken while a result waits on out_ready. Configuration writes take effect
// at once and must only be issued while the unit is idle; writing
// volume_default also reloads the current encoder mode. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module camera_source_and_volume_controller_unit #(
	parameter int unsigned FRONT_HOLD_TICKS = 1000,
	parameter int unsigned MODE_HOLD_TICKS  = 600
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// configuration write port
	input  logic                                cfg_we,
	input  logic [cscv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cscv_pkg::LEVEL_W-1:0]        cfg_wdata,

	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [1:0]                          encoder_phases,
	input  logic [cscv_pkg::LEVEL_W-1:0]        first_reading,
	input  logic [cscv_pkg::LEVEL_W-1:0]        second_reading,
	input  logic [1:0]                          readings_valid,
	input  logic                                rear_gear,

	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          camera_source,
	output logic                                video_enable,
	output logic                                front_select,
	output logic                                third_select,
	output logic                                volume_active,
	output logic [1:0]                          menu_phases,
	output logic [1:0]                          volume_pulse,
	output logic                                volume_bar_blip
);
	import cscv_pkg::*;

	cfg_t  cfg_q;
	item_t item_in;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;
	logic  stall;
	logic  advance;
	logic  vdef_load;

	// ---------------- configuration registers ----------------
	assign vdef_load = cfg_we && (cfg_idx_t'(cfg_index) == REG_VOLUME_DEFAULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.no_button_level      <= '0;
			cfg_q.camera_button_level  <= '0;
			cfg_q.audio_button_level   <= '0;
			cfg_q.match_window         <= MATCH_WINDOW_RST;
			cfg_q.third_channel_enable <= 1'b0;
			cfg_q.volume_default       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_NO_BUTTON_LEVEL: cfg_q.no_button_level      <= cfg_wdata;
				REG_CAMERA_LEVEL:    cfg_q.camera_button_level  <= cfg_wdata;
				REG_AUDIO_LEVEL:     cfg_q.audio_button_level   <= cfg_wdata;
				REG_MATCH_WINDOW:    cfg_q.match_window         <= cfg_wdata;
				REG_THIRD_ENABLE:    cfg_q.third_channel_enable <= cfg_wdata[0];
				REG_VOLUME_DEFAULT:  cfg_q.volume_default       <= cfg_wdata[0];
				default: ; // unused indexes are dropped
			endcase
		end
	end

	// ---------------- flow control ----------------
	// Result register stalls when a result waits; the input register keeps
	// accepting while it is empty, so the two sides are decoupled by one slot.
	assign stall    = out_valid_q && !out_ready;
	assign in_ready = !valid_s1 || !stall;
	assign advance  = valid_s1 && !stall;

	assign item_in.mode           = item_mode_t'(mode);
	assign item_in.encoder_phases = encoder_phases;
	assign item_in.first_reading  = first_reading;
	assign item_in.second_reading = second_reading;
	assign item_in.readings_valid = readings_valid;
	assign item_in.rear_gear      = rear_gear;

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

	// ---------------- state update ----------------
	cscv_core #(
		.FRONT_HOLD_TICKS (FRONT_HOLD_TICKS),
		.MODE_HOLD_TICKS  (MODE_HOLD_TICKS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.cfg        (cfg_q),
		.vdef_load  (vdef_load),
		.vdef_value (cfg_wdata[0]),
		.res        (res)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign camera_source   = res_q.camera_source;
	assign video_enable    = res_q.video_enable;
	assign front_select    = res_q.front_select;
	assign third_select    = res_q.third_select;
	assign volume_active   = res_q.volume_active;
	assign menu_phases     = res_q.menu_phases;
	assign volume_pulse    = res_q.volume_pulse;
	assign volume_bar_blip = res_q.volume_bar_blip;

	// an item held in the input register is not lost or altered by a stall
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && stall |=> valid_s1 && $stable(item_s1))
		else $error("input register lost an item during a stall");

	// every processed item shows up as a result in the next cycle
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item did not reach the result register");

	// decoded select lines agree with the source code
	a_decode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (video_enable == (res_q.camera_source != SRC_OFF))
			&& (front_select == (res_q.camera_source == SRC_FRONT))
			&& (third_select == (res_q.camera_source == SRC_THIRD)))
		else $error("select outputs disagree with camera source");

endmodule
